@@ rtl/core/srv_pkg.sv @@
// shared widths, payload structs and constants for the refraction pipeline
// depends on nothing; used by the division cell and the top level
`default_nettype none

package srv_pkg;

	localparam int SQA_W   = 52;  // radicand width for the length root
	localparam int SQA_N   = SQA_W / 2;
	localparam int LEN_W   = 26;  // length in q.22
	localparam int NUM_W   = 40;  // dividend width
	localparam int QUO_W   = 16;  // quotient bits
	localparam int DIV_W   = 42;  // divisor shifted by the top step
	localparam int SQB_W   = 60;  // radicand width for the discriminant root
	localparam int SQB_N   = SQB_W / 2;
	localparam int ROOT_W  = 30;
	localparam int RT_W    = 52;
	localparam int ACC_W   = 56;

	localparam logic [15:0] UNIT_Q14 = 16'd16384;
	localparam logic signed [43:0] ONE_Q28 = 44'sd268435456;

	typedef logic signed [15:0] comp_t;
	typedef logic signed [RT_W-1:0] rt_t;

	typedef struct packed {
		comp_t [2:0] u;
		comp_t [2:0] n;
		logic [15:0] r;
		logic        zero;
	} sqa_pay_t;

	typedef struct packed {
		logic [2:0]  neg;
		comp_t [2:0] n;
		logic [15:0] r;
		logic        zero;
	} div_pay_t;

	typedef struct packed {
		rt_t [2:0]   rt;
		comp_t [2:0] n;
		logic        did;
		logic        zero;
	} sqb_pay_t;

endpackage

`default_nettype wire

@@ rtl/core/srv_sqrt_cell.sv @@
// one step of a digit-by-digit integer square root, with a carried payload
// standalone cell, chained by the top level
`default_nettype none

module srv_sqrt_cell #(
	parameter int W    = 52,
	parameter int STEP = 0,
	parameter int PW   = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          cur_valid,
	input  logic [W-1:0]  cur_rem,
	input  logic [W-1:0]  cur_root,
	input  logic [PW-1:0] cur_pay,
	output logic          nxt_valid,
	output logic [W-1:0]  nxt_rem,
	output logic [W-1:0]  nxt_root,
	output logic [PW-1:0] nxt_pay
);

	localparam logic [W-1:0] BIT = {{(W-1){1'b0}}, 1'b1} << (W - 2 - 2 * STEP);

	logic          valid_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  root_q;
	logic [PW-1:0] pay_q;
	logic [W-1:0]  trial;
	logic          take;

	always_comb begin
		trial = cur_root + BIT;
		take  = cur_rem >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= cur_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= take ? cur_rem - trial : cur_rem;
			root_q <= take ? (cur_root >> 1) + BIT : cur_root >> 1;
			pay_q  <= cur_pay;
		end
	end

	assign nxt_valid = valid_q;
	assign nxt_rem   = rem_q;
	assign nxt_root  = root_q;
	assign nxt_pay   = pay_q;

endmodule

`default_nettype wire

@@ rtl/core/srv_div_cell.sv @@
// one restoring division step on three lanes sharing a divisor
// depends on srv_pkg
`default_nettype none

module srv_div_cell #(
	parameter int STEP = 0,
	parameter int PW   = 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               cur_valid,
	input  logic [srv_pkg::LEN_W-1:0]          cur_den,
	input  logic [2:0][srv_pkg::NUM_W-1:0]     cur_rem,
	input  logic [2:0][srv_pkg::QUO_W-1:0]     cur_quo,
	input  logic [PW-1:0]                      cur_pay,
	output logic                               nxt_valid,
	output logic [srv_pkg::LEN_W-1:0]          nxt_den,
	output logic [2:0][srv_pkg::NUM_W-1:0]     nxt_rem,
	output logic [2:0][srv_pkg::QUO_W-1:0]     nxt_quo,
	output logic [PW-1:0]                      nxt_pay
);

	import srv_pkg::*;

	logic                   valid_q;
	logic [LEN_W-1:0]       den_q;
	logic [2:0][NUM_W-1:0]  rem_q;
	logic [2:0][QUO_W-1:0]  quo_q;
	logic [PW-1:0]          pay_q;
	logic [DIV_W-1:0]       shifted;
	logic [2:0]             take;
	logic [2:0][NUM_W-1:0]  rem_d;
	logic [2:0][QUO_W-1:0]  quo_d;

	always_comb begin
		shifted = DIV_W'(cur_den) << STEP;
		for (int i = 0; i < 3; i++) begin
			take[i]  = DIV_W'(cur_rem[i]) >= shifted;
			rem_d[i] = take[i] ? cur_rem[i] - shifted[NUM_W-1:0] : cur_rem[i];
			quo_d[i] = {cur_quo[i][QUO_W-2:0], take[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= cur_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_q <= cur_den;
			rem_q <= rem_d;
			quo_q <= quo_d;
			pay_q <= cur_pay;
		end
	end

	assign nxt_valid = valid_q;
	assign nxt_den   = den_q;
	assign nxt_rem   = rem_q;
	assign nxt_quo   = quo_q;
	assign nxt_pay   = pay_q;

endmodule

`default_nettype wire

@@ rtl/core/snell_refraction_vector.sv @@
// top level of the snell refraction pipeline
// depends on srv_pkg, srv_sqrt_cell and srv_div_cell
`default_nettype none

// usage
// - ray channel (ray_valid/ray_stall) takes one word per cycle unless
//   stalled: incident direction q3.12, unit normal q1.14, index ratio q2.14
// - result channel (res_valid/res_stall) gives one word per ray: refracted
//   direction q3.12 saturated, did_refract, zero_incident
// - one ray per clock sustained unless res_stall holds the result; a word
//   accepted at an edge crosses 85 register stages, that edge loading the
//   first, to the result channel (two input stages, a 26-cell root chain
//   for the length, a 16-cell divider chain, nine arithmetic stages, a
//   30-cell root chain for the discriminant, two output stages)
// - every chain cell does one root or division digit per cycle when not
//   stalled and hands its partial result to the next cell; rays overlap freely
// - when the result word is held by res_stall the whole pipe freezes and
//   ray_stall rises in the same cycle; nothing is dropped or repeated
// - reset clears only the valid bits of the pipe; data registers start
//   undefined and are never seen as results
// - total internal reflection and a zero incident vector give zero
//   components with did_refract low

module snell_refraction_vector (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ray_valid,
	output logic        ray_stall,
	input  logic signed [15:0] incident_x,
	input  logic signed [15:0] incident_y,
	input  logic signed [15:0] incident_z,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	input  logic [15:0] index_ratio,
	output logic        res_valid,
	input  logic        res_stall,
	output logic signed [15:0] refracted_x,
	output logic signed [15:0] refracted_y,
	output logic signed [15:0] refracted_z,
	output logic        did_refract,
	output logic        zero_incident
);

	import srv_pkg::*;

	localparam int APW = $bits(sqa_pay_t);
	localparam int DPW = $bits(div_pay_t);
	localparam int BPW = $bits(sqb_pay_t);

	// pipe advances unless the output word is held
	logic en;
	assign en        = !(res_valid && res_stall);
	assign ray_stall = !en;

	comp_t [2:0] u_in;
	comp_t [2:0] n_in;
	assign u_in[0] = incident_x;
	assign u_in[1] = incident_y;
	assign u_in[2] = incident_z;
	assign n_in[0] = normal_x;
	assign n_in[1] = normal_y;
	assign n_in[2] = normal_z;

	// stage 1: squares of the incident components
	logic signed [31:0] usq_d [3];
	logic        v_s1;
	logic [30:0] usq_s1 [3];
	comp_t [2:0] u_s1, n_s1;
	logic [15:0] r_s1;

	// stage 2: squared length and root radicand
	logic [31:0] l2;
	logic        v_s2;
	logic [SQA_W-1:0] rad_s2;
	sqa_pay_t    pay_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			usq_d[i] = $signed(u_in[i]) * $signed(u_in[i]);
		end
		l2 = 32'(usq_s1[0]) + 32'(usq_s1[1]) + 32'(usq_s1[2]);
	end

	// length root chain
	logic             a_valid [SQA_N+1];
	logic [SQA_W-1:0] a_rem   [SQA_N+1];
	logic [SQA_W-1:0] a_root  [SQA_N+1];
	logic [APW-1:0]   a_pay   [SQA_N+1];

	assign a_valid[0] = v_s2;
	assign a_rem[0]   = rad_s2;
	assign a_root[0]  = '0;
	assign a_pay[0]   = pay_s2;

	for (genvar k = 0; k < SQA_N; k++) begin : g_sqa
		srv_sqrt_cell #(.W(SQA_W), .STEP(k), .PW(APW)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.cur_valid (a_valid[k]),
			.cur_rem   (a_rem[k]),
			.cur_root  (a_root[k]),
			.cur_pay   (a_pay[k]),
			.nxt_valid (a_valid[k+1]),
			.nxt_rem   (a_rem[k+1]),
			.nxt_root  (a_root[k+1]),
			.nxt_pay   (a_pay[k+1])
		);
	end

	// stage 3: rounded dividends |u| * 2^24 + len / 2
	sqa_pay_t         a_out;
	logic [LEN_W-1:0] len;
	logic [15:0]      mag [3];
	logic             v_s3;
	logic [LEN_W-1:0] den_s3;
	logic [2:0][NUM_W-1:0] num_s3;
	div_pay_t         dpay_s3;

	always_comb begin
		a_out = sqa_pay_t'(a_pay[SQA_N]);
		len   = a_root[SQA_N][LEN_W-1:0];
		for (int i = 0; i < 3; i++) begin
			mag[i] = a_out.u[i][15] ? -a_out.u[i] : a_out.u[i];
		end
	end

	// divider chain, one quotient bit per cell
	logic                  d_valid [QUO_W+1];
	logic [LEN_W-1:0]      d_den   [QUO_W+1];
	logic [2:0][NUM_W-1:0] d_rem   [QUO_W+1];
	logic [2:0][QUO_W-1:0] d_quo   [QUO_W+1];
	logic [DPW-1:0]        d_pay   [QUO_W+1];

	assign d_valid[0] = v_s3;
	assign d_den[0]   = den_s3;
	assign d_rem[0]   = num_s3;
	assign d_quo[0]   = '0;
	assign d_pay[0]   = dpay_s3;

	for (genvar k = 0; k < QUO_W; k++) begin : g_div
		srv_div_cell #(.STEP(QUO_W - 1 - k), .PW(DPW)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.cur_valid (d_valid[k]),
			.cur_den   (d_den[k]),
			.cur_rem   (d_rem[k]),
			.cur_quo   (d_quo[k]),
			.cur_pay   (d_pay[k]),
			.nxt_valid (d_valid[k+1]),
			.nxt_den   (d_den[k+1]),
			.nxt_rem   (d_rem[k+1]),
			.nxt_quo   (d_quo[k+1]),
			.nxt_pay   (d_pay[k+1])
		);
	end

	// stage 4: clamp and sign the unit vector
	div_pay_t    d_out;
	logic [15:0] qc [3];
	logic        v_s4;
	comp_t [2:0] uv_s4, n_s4;
	logic [15:0] r_s4;
	logic        zero_s4;

	always_comb begin
		d_out = div_pay_t'(d_pay[QUO_W]);
		for (int i = 0; i < 3; i++) begin
			qc[i] = (d_quo[QUO_W][i] > UNIT_Q14) ? UNIT_Q14 : d_quo[QUO_W][i];
		end
	end

	// stage 5: uv*n products and r*r
	logic               v_s5;
	logic signed [31:0] uvn_s5 [3];
	logic [31:0]        rrp_s5;
	comp_t [2:0]        uv_s5, n_s5;
	logic [15:0]        r_s5;
	logic               zero_s5;

	// stage 6: dot product rounded to q.14, r*r rounded to q.14
	logic signed [31:0] dsum;
	logic [32:0]        rrsum;
	logic               v_s6;
	logic signed [17:0] dt_s6;
	logic [18:0]        rr_s6;
	comp_t [2:0]        uv_s6, n_s6;
	logic [15:0]        r_s6;
	logic               zero_s6;

	always_comb begin
		dsum  = uvn_s5[0] + uvn_s5[1] + uvn_s5[2] + 32'sd8192;
		rrsum = {1'b0, rrp_s5} + 33'd8192;
	end

	// stage 7: dt*dt and n*dt
	logic               v_s7;
	logic signed [35:0] dt2_s7;
	logic signed [33:0] ndt_s7 [3];
	comp_t [2:0]        uv_s7, n_s7;
	logic [15:0]        r_s7;
	logic [18:0]        rr_s7;
	logic               zero_s7;

	// stage 8: 1 - dt*dt and t = uv - n*dt in q.28
	logic               v_s8;
	logic signed [35:0] omd_s8;
	logic signed [35:0] t_s8 [3];
	comp_t [2:0]        n_s8;
	logic [15:0]        r_s8;
	logic [18:0]        rr_s8;
	logic               zero_s8;

	// stage 9: partial products of rr*omd and r*t, split at bit 18
	logic signed [17:0] omd_hi;
	logic signed [17:0] t_hi [3];
	logic               v_s9;
	logic [36:0]        pplo_s9;
	logic signed [37:0] pphi_s9;
	logic [33:0]        rtlo_s9 [3];
	logic signed [34:0] rthi_s9 [3];
	comp_t [2:0]        n_s9;
	logic               zero_s9;

	always_comb begin
		omd_hi = omd_s8[35:18];
		for (int i = 0; i < 3; i++) begin
			t_hi[i] = t_s8[i][35:18];
		end
	end

	// stage 10: full products
	logic               v_s10;
	logic signed [ACC_W-1:0] prod_s10;
	rt_t [2:0]          rt_s10;
	comp_t [2:0]        n_s10;
	logic               zero_s10;

	// stage 11: discriminant and its root radicand
	logic signed [ACC_W-1:0] prodr;
	logic signed [41:0] pq;
	logic signed [43:0] disc;
	logic               pos;
	logic               v_s11;
	logic [SQB_W-1:0]   rad_s11;
	sqb_pay_t           bpay_s11;

	always_comb begin
		prodr = prod_s10 + (56'sd1 <<< 13);
		pq    = prodr[ACC_W-1:14];
		disc  = ONE_Q28 - 44'(pq);
		pos   = disc > 44'sd0;
	end

	// discriminant root chain
	logic             b_valid [SQB_N+1];
	logic [SQB_W-1:0] b_rem   [SQB_N+1];
	logic [SQB_W-1:0] b_root  [SQB_N+1];
	logic [BPW-1:0]   b_pay   [SQB_N+1];

	assign b_valid[0] = v_s11;
	assign b_rem[0]   = rad_s11;
	assign b_root[0]  = '0;
	assign b_pay[0]   = bpay_s11;

	for (genvar k = 0; k < SQB_N; k++) begin : g_sqb
		srv_sqrt_cell #(.W(SQB_W), .STEP(k), .PW(BPW)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.cur_valid (b_valid[k]),
			.cur_rem   (b_rem[k]),
			.cur_root  (b_root[k]),
			.cur_pay   (b_pay[k]),
			.nxt_valid (b_valid[k+1]),
			.nxt_rem   (b_rem[k+1]),
			.nxt_root  (b_root[k+1]),
			.nxt_pay   (b_pay[k+1])
		);
	end

	// stage 12: n * sqrt(disc)
	sqb_pay_t           b_out;
	logic [ROOT_W-1:0]  sq;
	logic               v_s12;
	logic signed [46:0] nsq_s12 [3];
	rt_t [2:0]          rt_s12;
	logic               did_s12;
	logic               zero_s12;

	always_comb begin
		b_out = sqb_pay_t'(b_pay[SQB_N]);
		sq    = b_root[SQB_N][ROOT_W-1:0];
	end

	// stage 13: combine, round to q3.12, saturate
	logic signed [ACC_W-1:0] acc [3];
	logic signed [25:0]      rq [3];
	comp_t [2:0]             res_d;
	logic               v_s13;
	comp_t [2:0]        res_s13;
	logic               did_s13;
	logic               zero_s13;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc[i] = ACC_W'(rt_s12[i]) - (ACC_W'(nsq_s12[i]) <<< 4) + (56'sd1 <<< 29);
			rq[i]  = acc[i][ACC_W-1:30];
			if (!did_s12) begin
				res_d[i] = '0;
			end else if (rq[i] > 26'sd32767) begin
				res_d[i] = 16'sh7fff;
			end else if (rq[i] < -26'sd32768) begin
				res_d[i] = -16'sh8000;
			end else begin
				res_d[i] = rq[i][15:0];
			end
		end
	end

	// valid bits of the arithmetic stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else if (en) begin
			v_s1  <= ray_valid;
			v_s2  <= v_s1;
			v_s3  <= a_valid[SQA_N];
			v_s4  <= d_valid[QUO_W];
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= b_valid[SQB_N];
			v_s13 <= v_s12;
		end
	end

	// data of the arithmetic stages
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				usq_s1[i] <= usq_d[i][30:0];
			end
			u_s1 <= u_in;
			n_s1 <= n_in;
			r_s1 <= index_ratio;

			rad_s2      <= {l2, 20'd0};
			pay_s2.u    <= u_s1;
			pay_s2.n    <= n_s1;
			pay_s2.r    <= r_s1;
			pay_s2.zero <= l2 == 32'd0;

			den_s3 <= len;
			for (int i = 0; i < 3; i++) begin
				num_s3[i]      <= {mag[i], 24'd0} + {15'd0, len[LEN_W-1:1]};
				dpay_s3.neg[i] <= a_out.u[i][15];
			end
			dpay_s3.n    <= a_out.n;
			dpay_s3.r    <= a_out.r;
			dpay_s3.zero <= a_out.zero;

			for (int i = 0; i < 3; i++) begin
				uv_s4[i] <= d_out.neg[i] ? -qc[i] : qc[i];
			end
			n_s4    <= d_out.n;
			r_s4    <= d_out.r;
			zero_s4 <= d_out.zero;

			for (int i = 0; i < 3; i++) begin
				uvn_s5[i] <= uv_s4[i] * n_s4[i];
			end
			rrp_s5  <= r_s4 * r_s4;
			uv_s5   <= uv_s4;
			n_s5    <= n_s4;
			r_s5    <= r_s4;
			zero_s5 <= zero_s4;

			dt_s6   <= dsum[31:14];
			rr_s6   <= rrsum[32:14];
			uv_s6   <= uv_s5;
			n_s6    <= n_s5;
			r_s6    <= r_s5;
			zero_s6 <= zero_s5;

			dt2_s7 <= dt_s6 * dt_s6;
			for (int i = 0; i < 3; i++) begin
				ndt_s7[i] <= n_s6[i] * dt_s6;
			end
			uv_s7   <= uv_s6;
			n_s7    <= n_s6;
			r_s7    <= r_s6;
			rr_s7   <= rr_s6;
			zero_s7 <= zero_s6;

			omd_s8 <= 36'(ONE_Q28) - dt2_s7;
			for (int i = 0; i < 3; i++) begin
				t_s8[i] <= {{6{uv_s7[i][15]}}, uv_s7[i], 14'd0} - 36'(ndt_s7[i]);
			end
			n_s8    <= n_s7;
			r_s8    <= r_s7;
			rr_s8   <= rr_s7;
			zero_s8 <= zero_s7;

			pplo_s9 <= rr_s8 * omd_s8[17:0];
			pphi_s9 <= $signed({1'b0, rr_s8}) * omd_hi;
			for (int i = 0; i < 3; i++) begin
				rtlo_s9[i] <= r_s8 * t_s8[i][17:0];
				rthi_s9[i] <= $signed({1'b0, r_s8}) * t_hi[i];
			end
			n_s9    <= n_s8;
			zero_s9 <= zero_s8;

			prod_s10 <= (ACC_W'(pphi_s9) <<< 18) + ACC_W'(pplo_s9);
			for (int i = 0; i < 3; i++) begin
				rt_s10[i] <= (RT_W'(rthi_s9[i]) <<< 18) + RT_W'(rtlo_s9[i]);
			end
			n_s10    <= n_s9;
			zero_s10 <= zero_s9;

			rad_s11       <= pos ? {disc[39:0], 20'd0} : '0;
			bpay_s11.rt   <= rt_s10;
			bpay_s11.n    <= n_s10;
			bpay_s11.did  <= pos && !zero_s10;
			bpay_s11.zero <= zero_s10;

			for (int i = 0; i < 3; i++) begin
				nsq_s12[i] <= b_out.n[i] * $signed({1'b0, sq});
			end
			rt_s12   <= b_out.rt;
			did_s12  <= b_out.did;
			zero_s12 <= b_out.zero;

			res_s13  <= res_d;
			did_s13  <= did_s12;
			zero_s13 <= zero_s12;
		end
	end

	assign res_valid     = v_s13;
	assign refracted_x   = res_s13[0];
	assign refracted_y   = res_s13[1];
	assign refracted_z   = res_s13[2];
	assign did_refract   = did_s13;
	assign zero_incident = zero_s13;

`ifndef SYNTHESIS
	a_zero_no_refract: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && zero_incident |-> !did_refract)
		else $error("zero incident word flagged as refracted");

	a_tir_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !did_refract |->
		refracted_x == 16'sd0 && refracted_y == 16'sd0 && refracted_z == 16'sd0)
		else $error("nonzero components without refraction");

	a_pipe_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s12 && !en |=> v_s12 && $stable(did_s12))
		else $error("pipe moved while output held");
`endif

endmodule

`default_nettype wire
